### rtl/bchq_pkg.sv
`timescale 1ns / 1ps

package bchq_pkg;

    // Width of the tick counter and of every stored time stamp.
    localparam int TIME_BITS = 32;

    // APB address width: just enough for the register byte addresses.
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // Click counter width and its saturation value.
    localparam int CLICK_BITS = 7;
    localparam logic [CLICK_BITS-1:0] CLICK_MAX = '1;

    typedef logic [TIME_BITS-1:0] t_time;

    // Register map, as word indexes.
    typedef enum logic [2:0] {
        REG_ACTIVE_LOW      = 3'd0,
        REG_NORMALLY_CLOSED = 3'd1,
        REG_DEBOUNCE_TICKS  = 3'd2,
        REG_HOLD_TICKS      = 3'd3,
        REG_REPEAT_TICKS    = 3'd4,
        REG_CLICK_WINDOW    = 3'd5
    } t_reg_idx;

    // Register reset values.
    localparam logic        RST_ACTIVE_LOW      = 1'b1;
    localparam logic        RST_NORMALLY_CLOSED = 1'b0;
    localparam logic [7:0]  RST_DEBOUNCE_TICKS  = 8'd50;
    localparam logic [15:0] RST_HOLD_TICKS      = 16'd500;
    localparam logic [15:0] RST_REPEAT_TICKS    = 16'd200;
    localparam logic [15:0] RST_CLICK_WINDOW    = 16'd400;

    // Bit positions in the event flag word.
    localparam int FLAG_PRESSED  = 0;
    localparam int FLAG_RELEASED = 1;
    localparam int FLAG_HOLD     = 2;
    localparam int FLAG_CLAMP    = 3;
    localparam int FLAG_WASHELD  = 4;
    localparam int FLAG_CLICKS   = 5;
    localparam int FLAG_BITS     = 6;

    typedef struct packed {
        logic        active_low;
        logic        normally_closed;
        logic [7:0]  debounce_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] repeat_ticks;
        logic [15:0] click_window_ticks;
    } t_cfg;

    typedef struct packed {
        logic       raw_level;
        logic [3:0] clear_flags;
        logic       take_clicks;
    } t_item;

    typedef struct packed {
        logic                  pressed_event;
        logic                  released_event;
        logic                  hold_event;
        logic                  clamp_event;
        logic                  still_held;
        logic                  multiclick_ready;
        logic                  clicks_valid;
        logic [CLICK_BITS-1:0] click_count;
    } t_result;

endpackage

### rtl/bchq_if.sv
`timescale 1ns / 1ps

// Input channel: one tick sample per transfer.
interface bchq_in_if;
    logic       valid;
    logic       ready;
    logic       raw_level;
    logic [3:0] clear_flags;
    logic       take_clicks;

    modport source (output valid, output raw_level, output clear_flags,
                    output take_clicks, input ready);
    modport sink   (input valid, input raw_level, input clear_flags,
                    input take_clicks, output ready);
endinterface

// Result channel: one result per tick.
interface bchq_out_if;
    logic                           valid;
    logic                           ready;
    logic                           pressed_event;
    logic                           released_event;
    logic                           hold_event;
    logic                           clamp_event;
    logic                           still_held;
    logic                           multiclick_ready;
    logic                           clicks_valid;
    logic [bchq_pkg::CLICK_BITS-1:0] click_count;

    modport source (output valid, output pressed_event, output released_event,
                    output hold_event, output clamp_event, output still_held,
                    output multiclick_ready, output clicks_valid,
                    output click_count, input ready);
    modport sink   (input valid, input pressed_event, input released_event,
                    input hold_event, input clamp_event, input still_held,
                    input multiclick_ready, input clicks_valid,
                    input click_count, output ready);
endinterface

### rtl/bchq_regs.sv
`timescale 1ns / 1ps

module bchq_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bchq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bchq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bchq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output bchq_pkg::t_cfg                     o_cfg
);

    bchq_pkg::t_cfg   r_cfg;
    bchq_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = bchq_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes take effect in the access phase of the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low         <= bchq_pkg::RST_ACTIVE_LOW;
            r_cfg.normally_closed    <= bchq_pkg::RST_NORMALLY_CLOSED;
            r_cfg.debounce_ticks     <= bchq_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.hold_ticks         <= bchq_pkg::RST_HOLD_TICKS;
            r_cfg.repeat_ticks       <= bchq_pkg::RST_REPEAT_TICKS;
            r_cfg.click_window_ticks <= bchq_pkg::RST_CLICK_WINDOW;
        end else if (w_wr) begin
            unique case (w_idx)
                bchq_pkg::REG_ACTIVE_LOW:      r_cfg.active_low <= pwdata[0];
                bchq_pkg::REG_NORMALLY_CLOSED: r_cfg.normally_closed <= pwdata[0];
                bchq_pkg::REG_DEBOUNCE_TICKS:  r_cfg.debounce_ticks <= pwdata[7:0];
                bchq_pkg::REG_HOLD_TICKS:      r_cfg.hold_ticks <= pwdata[15:0];
                bchq_pkg::REG_REPEAT_TICKS:    r_cfg.repeat_ticks <= pwdata[15:0];
                bchq_pkg::REG_CLICK_WINDOW:    r_cfg.click_window_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data mux; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            bchq_pkg::REG_ACTIVE_LOW:      prdata[0] = r_cfg.active_low;
            bchq_pkg::REG_NORMALLY_CLOSED: prdata[0] = r_cfg.normally_closed;
            bchq_pkg::REG_DEBOUNCE_TICKS:  prdata[7:0] = r_cfg.debounce_ticks;
            bchq_pkg::REG_HOLD_TICKS:      prdata[15:0] = r_cfg.hold_ticks;
            bchq_pkg::REG_REPEAT_TICKS:    prdata[15:0] = r_cfg.repeat_ticks;
            bchq_pkg::REG_CLICK_WINDOW:    prdata[15:0] = r_cfg.click_window_ticks;
            default: ;
        endcase
    end

endmodule

### rtl/bchq_core.sv
`timescale 1ns / 1ps

module bchq_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bchq_pkg::t_item   i_item,
    input  bchq_pkg::t_cfg    i_cfg,
    output bchq_pkg::t_result o_res
);

    localparam int TB = bchq_pkg::TIME_BITS;
    localparam int CB = bchq_pkg::CLICK_BITS;
    localparam int FB = bchq_pkg::FLAG_BITS;

    bchq_pkg::t_time r_tick,     n_tick;
    logic            r_last,     n_last;
    bchq_pkg::t_time r_press,    n_press;
    bchq_pkg::t_time r_release,  n_release;
    bchq_pkg::t_time r_deadline, n_deadline;
    logic [CB-1:0]   r_clicks,   n_clicks;
    logic [FB-1:0]   r_flags,    n_flags;

    logic            w_level;
    logic            w_valid;
    bchq_pkg::t_time w_db;
    bchq_pkg::t_time w_hold;
    bchq_pkg::t_time w_rep;
    bchq_pkg::t_time w_win;
    bchq_pkg::t_time w_since_rel;
    bchq_pkg::t_time w_since_press;
    bchq_pkg::t_time w_since_press1;
    bchq_pkg::t_time w_past_dl;
    logic [FB-1:0]   w_flags;

    assign w_db   = {{(TB-8){1'b0}}, i_cfg.debounce_ticks};
    assign w_hold = {{(TB-16){1'b0}}, i_cfg.hold_ticks};
    assign w_rep  = {{(TB-16){1'b0}}, i_cfg.repeat_ticks};
    assign w_win  = {{(TB-16){1'b0}}, i_cfg.click_window_ticks};

    // One tick of the qualifier: edges, hold, clamp and click window.
    always_comb begin
        n_tick     = r_tick + 1'b1;
        w_level    = i_item.raw_level ^ i_cfg.active_low ^ i_cfg.normally_closed;
        n_last     = w_level;
        n_press    = r_press;
        n_release  = r_release;
        n_deadline = r_deadline;
        n_clicks   = r_clicks;
        w_flags    = r_flags;

        w_since_rel   = n_tick - r_release;
        w_since_press = n_tick - r_press;

        // Debounced press.
        if (w_level && !r_last && (w_since_rel > w_db)) begin
            n_press                       = n_tick;
            w_flags[bchq_pkg::FLAG_PRESSED] = 1'b1;
            if (r_clicks != bchq_pkg::CLICK_MAX) begin
                n_clicks = r_clicks + 1'b1;
            end
            n_deadline = n_tick + w_win;
        end

        // Debounced release.
        if (!w_level && r_last && (w_since_press > w_db)) begin
            n_release                        = n_tick;
            w_flags[bchq_pkg::FLAG_WASHELD]  = 1'b0;
            w_flags[bchq_pkg::FLAG_RELEASED] = 1'b1;
        end

        // Hold and clamp use the press time after this tick's edge.
        w_since_press1 = n_tick - n_press;
        if (w_level && !w_flags[bchq_pkg::FLAG_WASHELD] && (w_since_press1 > w_hold)) begin
            w_flags[bchq_pkg::FLAG_WASHELD] = 1'b1;
            w_flags[bchq_pkg::FLAG_HOLD]    = 1'b1;
        end
        if (w_level && w_flags[bchq_pkg::FLAG_WASHELD] && (w_since_press1 > w_rep)) begin
            n_clicks                      = '0;
            n_press                       = n_tick;
            w_flags[bchq_pkg::FLAG_CLAMP] = 1'b1;
        end

        // Click window expired: wrap-safe "after deadline" test.
        w_past_dl = n_tick - n_deadline;
        if (!w_level && (n_clicks != '0) && (w_past_dl != '0) && !w_past_dl[TB-1]) begin
            w_flags[bchq_pkg::FLAG_CLICKS] = 1'b1;
        end

        w_valid = i_item.take_clicks && w_flags[bchq_pkg::FLAG_CLICKS];

        o_res.pressed_event    = w_flags[bchq_pkg::FLAG_PRESSED];
        o_res.released_event   = w_flags[bchq_pkg::FLAG_RELEASED];
        o_res.hold_event       = w_flags[bchq_pkg::FLAG_HOLD];
        o_res.clamp_event      = w_flags[bchq_pkg::FLAG_CLAMP];
        o_res.still_held       = w_flags[bchq_pkg::FLAG_WASHELD];
        o_res.multiclick_ready = w_flags[bchq_pkg::FLAG_CLICKS];
        o_res.clicks_valid     = w_valid;
        o_res.click_count      = w_valid ? n_clicks : '0;

        // Clears apply after the flags are reported.
        n_flags = w_flags & ~{{(FB-4){1'b0}}, i_item.clear_flags};
        if (w_valid) begin
            n_flags[bchq_pkg::FLAG_CLICKS] = 1'b0;
            n_clicks                       = '0;
        end
    end

    // State registers advance once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_last     <= 1'b0;
            r_press    <= '0;
            r_release  <= '0;
            r_deadline <= '0;
            r_clicks   <= '0;
            r_flags    <= '0;
        end else if (i_step) begin
            r_tick     <= n_tick;
            r_last     <= n_last;
            r_press    <= n_press;
            r_release  <= n_release;
            r_deadline <= n_deadline;
            r_clicks   <= n_clicks;
            r_flags    <= n_flags;
        end
    end

    // A taken count always empties the counter and the multiclick flag.
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.clicks_valid |=> r_clicks == '0 && !r_flags[bchq_pkg::FLAG_CLICKS])
        else $error("click count not cleared after take");

    // A count is only returned while a multiclick is flagged. A clamp after the
    // flag was raised can leave the count at zero, so the count itself is free.
    a_valid_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.clicks_valid |-> o_res.multiclick_ready)
        else $error("click count returned without multiclick");

    // The tick counter moves by exactly one per processed tick.
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_tick == $past(r_tick) + 1'b1)
        else $error("tick counter skipped");

endmodule

### rtl/button_click_hold_qualifier_unit.sv
`timescale 1ns / 1ps

// Button click and hold qualifier. Each input transfer is one millisecond tick
// carrying the raw pin level, event clears and a click-take request; each tick
// yields exactly one result transfer. The block takes one tick per clock
// cycle: a tick is captured in the input register, evaluated in a single
// combinational pass against the stored times and flags, and its result is
// placed in the output register when that is free. The output register frees
// itself in the same cycle it is taken, so throughput stays at one tick per
// cycle unless the result side stalls. Configuration must be written through
// the APB port only while no ticks are in flight; the block does not check it.
module button_click_hold_qualifier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bchq_in_if.sink                            i_in,
    bchq_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bchq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bchq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bchq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    bchq_pkg::t_cfg    w_cfg;
    bchq_pkg::t_item   r_item;
    logic              r_in_valid;
    bchq_pkg::t_result w_res;
    bchq_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_advance;
    logic              w_in_ready;

    bchq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bchq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // The held tick moves on when the output register is empty or being taken.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_item.raw_level   <= i_in.raw_level;
            r_item.clear_flags <= i_in.clear_flags;
            r_item.take_clicks <= i_in.take_clicks;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.pressed_event    = r_out.pressed_event;
    assign o_out.released_event   = r_out.released_event;
    assign o_out.hold_event       = r_out.hold_event;
    assign o_out.clamp_event      = r_out.clamp_event;
    assign o_out.still_held       = r_out.still_held;
    assign o_out.multiclick_ready = r_out.multiclick_ready;
    assign o_out.clicks_valid     = r_out.clicks_valid;
    assign o_out.click_count      = r_out.click_count;

    // A tick waiting on a stalled result stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && r_item == $past(r_item))
        else $error("held tick lost");

    // A pending result is never overwritten before its transfer.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> !r_out_valid || o_out.ready)
        else $error("result overwritten");

    // A returned count is always flagged valid in the output register.
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.clicks_valid |-> r_out.click_count == '0)
        else $error("click count without valid");

endmodule
